// ===== rtl/sobel_pkg.sv =====
// Shared types and constants for the Sobel RGB gradient magnitude block.
// No dependencies; every other file imports this package.
package sobel_pkg;

  localparam int CHANNEL_BITS   = 8;
  localparam int MAX_LINE_WIDTH = 1024;
  localparam int PIX_W          = 3 * CHANNEL_BITS;

  localparam int FW_W        = 11;
  localparam int FH_W        = 12;
  localparam int ROW_W       = FH_W + 1;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;

  localparam int GRAD_W = CHANNEL_BITS + 2;
  localparam int SUM_W  = 2 * GRAD_W + 1;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int MAG_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic                    mode;
    logic [CHANNEL_BITS-1:0] in_red;
    logic [CHANNEL_BITS-1:0] in_green;
    logic [CHANNEL_BITS-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_red;
    logic [MAG_W-1:0] mag_green;
    logic [MAG_W-1:0] mag_blue;
    logic             frame_end;
  } out_item_t;

  // Request leaving the position counters.
  typedef struct packed {
    logic       valid;
    logic       emit;
    logic       frame_end;
    logic [8:0] mask;
  } ctrl_t;

  typedef struct packed {
    logic                   valid;
    logic                   frame_end;
    logic [2:0][GRAD_W-1:0] ax;
    logic [2:0][GRAD_W-1:0] ay;
  } grad_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_lane_t;

  typedef struct packed {
    logic           valid;
    logic           frame_end;
    sq_lane_t [2:0] lane;
  } sq_cell_t;

endpackage

// ===== rtl/sobel_ctrl.sv =====
// Frame registers, input and output position counters, border mask.
// Depends on sobel_pkg.
module sobel_ctrl #(
  parameter int MAX_LINE_WIDTH = sobel_pkg::MAX_LINE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  sobel_pkg::in_item_t                  in_data,
  input  logic                                 cfg_we,
  input  logic [sobel_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [$clog2(MAX_LINE_WIDTH)-1:0]    rd_col,
  output sobel_pkg::ctrl_t                     a_ctrl_r,
  output logic [sobel_pkg::PIX_W-1:0]          a_pix_r,
  output logic [$clog2(MAX_LINE_WIDTH)-1:0]    a_col_r
);
  import sobel_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int WW    = COL_W + 1;

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] ocol_r, ocol_nxt;
  logic [FH_W-1:0]  orow_r, orow_nxt;
  logic [WW-1:0]    w_eff;
  logic [FH_W-1:0]  h_eff;
  logic             done, ignore, take, emit, fe, col_last, ocol_last;
  logic [2:0]       row_ok, col_ok;
  logic [PIX_W-1:0] pix;
  ctrl_t            ctrl_nxt;

  always_comb begin
    if (32'(frame_width_r) > MAX_LINE_WIDTH) begin
      w_eff = WW'(MAX_LINE_WIDTH);
    end else if (frame_width_r < FW_W'(2)) begin
      w_eff = WW'(2);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    h_eff = (frame_height_r < FH_W'(2)) ? FH_W'(2) : frame_height_r;
  end

  assign done   = row_r >= {1'b0, h_eff};
  assign ignore = (in_data.mode == MODE_DRAIN) && !done;
  assign take   = adv && in_valid && !ignore;
  assign pix    = (in_data.mode == MODE_PIXEL && !done)
                ? {in_data.in_blue, in_data.in_green, in_data.in_red} : '0;
  assign emit   = (row_r >= ROW_W'(2)) || (row_r == ROW_W'(1) && col_r != '0);
  assign col_last  = (WW'(col_r) + WW'(1)) >= w_eff;
  assign ocol_last = (WW'(ocol_r) + WW'(1)) == w_eff;
  assign fe        = emit && (orow_r == h_eff - FH_W'(1)) && ocol_last;
  assign rd_col    = col_r;

  assign row_ok[0] = orow_r != '0;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = (orow_r + FH_W'(1)) < h_eff;
  assign col_ok[0] = ocol_r != '0;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = (WW'(ocol_r) + WW'(1)) < w_eff;

  always_comb begin
    ctrl_nxt.valid     = in_valid && !ignore;
    ctrl_nxt.emit      = emit;
    ctrl_nxt.frame_end = fe;
    for (int k = 0; k < 9; k++) begin
      ctrl_nxt.mask[k] = row_ok[k / 3] & col_ok[k % 3];
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (take) begin
      col_nxt = col_last ? '0 : col_r + COL_W'(1);
      row_nxt = col_last ? row_r + ROW_W'(1) : row_r;
      if (emit) begin
        ocol_nxt = ocol_last ? '0 : ocol_r + COL_W'(1);
        orow_nxt = ocol_last ? orow_r + FH_W'(1) : orow_r;
      end
      if (fe) begin
        col_nxt  = '0;
        row_nxt  = '0;
        ocol_nxt = '0;
        orow_nxt = '0;
      end
    end
    if (cfg_we) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      ocol_r         <= '0;
      orow_r         <= '0;
      a_ctrl_r       <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (adv) begin
        a_ctrl_r <= ctrl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pix_r <= pix;
      a_col_r <= col_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < w_eff)
    else $error("input column beyond line width");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && fe |=> (col_r == '0 && row_r == '0 && ocol_r == '0 && orow_r == '0))
    else $error("counters not cleared after frame end");

  a_frame_end_req: assert property (@(posedge clk) disable iff (!rst_n)
    take && fe |=> (a_ctrl_r.valid && a_ctrl_r.emit && a_ctrl_r.frame_end))
    else $error("frame end request lost");
`endif

endmodule

// ===== rtl/sobel_window.sv =====
// Line stores, 3x3 window columns and per-channel Sobel gradients.
// Depends on sobel_pkg.
module sobel_window #(
  parameter int MAX_LINE_WIDTH = sobel_pkg::MAX_LINE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              clear,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0] rd_col,
  input  sobel_pkg::ctrl_t                  a_ctrl,
  input  logic [sobel_pkg::PIX_W-1:0]       a_pix,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0] a_col,
  output sobel_pkg::grad_t                  grad_r
);
  import sobel_pkg::*;

  // Each entry holds {upper line, lower line} at one column.
  logic [2*PIX_W-1:0]          mem [MAX_LINE_WIDTH];
  logic [2*PIX_W-1:0]          rd_r;
  logic [2:0][2:0][PIX_W-1:0]  win_r, sh;
  logic [2:0][GRAD_W-1:0]      ax, ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mem[rd_col];
      if (a_ctrl.valid) begin
        mem[a_col] <= {rd_r[PIX_W-1:0], a_pix};
      end
    end
  end

  always_comb begin
    sh[0]    = win_r[1];
    sh[1]    = win_r[2];
    sh[2][0] = rd_r[2*PIX_W-1:PIX_W];
    sh[2][1] = rd_r[PIX_W-1:0];
    sh[2][2] = a_pix;
  end

  always_comb begin
    logic [8:0][CHANNEL_BITS-1:0] v;
    logic [GRAD_W-1:0] px, nx, py, ny;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        v[k] = a_ctrl.mask[k] ? sh[k % 3][k / 3][ch*CHANNEL_BITS +: CHANNEL_BITS] : '0;
      end
      px = GRAD_W'(v[2]) + {1'b0, v[5], 1'b0} + GRAD_W'(v[8]);
      nx = GRAD_W'(v[0]) + {1'b0, v[3], 1'b0} + GRAD_W'(v[6]);
      py = GRAD_W'(v[0]) + {1'b0, v[1], 1'b0} + GRAD_W'(v[2]);
      ny = GRAD_W'(v[6]) + {1'b0, v[7], 1'b0} + GRAD_W'(v[8]);
      ax[ch] = (px >= nx) ? px - nx : nx - px;
      ay[ch] = (py >= ny) ? py - ny : ny - py;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      win_r <= '0;
    end else if (adv && a_ctrl.valid) begin
      win_r <= a_ctrl.frame_end ? '0 : sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_r.valid <= 1'b0;
    end else if (adv) begin
      grad_r.valid <= a_ctrl.valid && a_ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grad_r.frame_end <= a_ctrl.frame_end;
      grad_r.ax        <= ax;
      grad_r.ay        <= ay;
    end
  end

endmodule

// ===== rtl/sobel_sqrt_cell.sv =====
// One restoring square-root step for three channels: two radicand bits in,
// one root bit out. Depends on sobel_pkg.
module sobel_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  sobel_pkg::sq_cell_t  cell_in,
  output sobel_pkg::sq_cell_t  cell_r
);
  import sobel_pkg::*;

  sq_cell_t cell_nxt;

  always_comb begin
    logic [REM_W-1:0] cur, trial;
    cell_nxt.valid     = cell_in.valid;
    cell_nxt.frame_end = cell_in.frame_end;
    for (int l = 0; l < 3; l++) begin
      cur   = {cell_in.lane[l].rem[REM_W-3:0], cell_in.lane[l].rad[RAD_W-1 -: 2]};
      trial = {1'b0, cell_in.lane[l].root, 2'b01};
      cell_nxt.lane[l].rad = {cell_in.lane[l].rad[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        cell_nxt.lane[l].rem  = cur - trial;
        cell_nxt.lane[l].root = {cell_in.lane[l].root[ROOT_W-2:0], 1'b1};
      end else begin
        cell_nxt.lane[l].rem  = cur;
        cell_nxt.lane[l].root = {cell_in.lane[l].root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r.frame_end <= cell_nxt.frame_end;
      cell_r.lane      <= cell_nxt.lane;
    end
  end

endmodule

// ===== rtl/sobel_rgb_gradient_magnitude_top.sv =====
// Throughput: one request per cycle sustained; the whole pipe holds on output stall.
// Path: a result leaves after the request that completes its 3x3
//   neighborhood (one line and one pixel after its own pixel), passing through the counter stage,
//   line store read and gradient stage, square stage, 11 square-root cells.
// Reset (synchronous, rst_n low): frame 640x480, counters, window and valids
//   cleared; line stores are not cleared and need no clearing pass.
module sobel_rgb_gradient_magnitude_top #(
  parameter int MAX_LINE_WIDTH = sobel_pkg::MAX_LINE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sobel_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sobel_pkg::out_item_t              out_data,
  input  logic                              cfg_we,
  input  logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sobel_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);

  logic             adv;
  logic [COL_W-1:0] rd_col, a_col;
  ctrl_t            a_ctrl;
  logic [PIX_W-1:0] a_pix;
  grad_t            grad;
  sq_cell_t         chain [ROOT_W+1];

  // Advance every stage together unless the finished result is held.
  assign adv      = !chain[ROOT_W].valid || out_ready;
  assign in_ready = adv;

  sobel_ctrl #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rd_col   (rd_col),
    .a_ctrl_r (a_ctrl),
    .a_pix_r  (a_pix),
    .a_col_r  (a_col)
  );

  // A register write restarts the frame: drop the window contents.
  sobel_window #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .clear (cfg_we),
    .rd_col(rd_col),
    .a_ctrl(a_ctrl),
    .a_pix (a_pix),
    .a_col (a_col),
    .grad_r(grad)
  );

  // Square stage: gx^2 + gy^2 per channel, loaded as radicand of the root chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid <= grad.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0].frame_end <= grad.frame_end;
      for (int l = 0; l < 3; l++) begin
        chain[0].lane[l].rad  <= RAD_W'(SUM_W'(grad.ax[l]) * SUM_W'(grad.ax[l])
                                      + SUM_W'(grad.ay[l]) * SUM_W'(grad.ay[l]));
        chain[0].lane[l].rem  <= '0;
        chain[0].lane[l].root <= '0;
      end
    end
  end

  // Root chain: each cell resolves one root bit and passes on to its neighbor.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    sobel_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .cell_in(chain[i]),
      .cell_r (chain[i+1])
    );
  end

  // The last cell is the output register.
  assign out_valid          = chain[ROOT_W].valid;
  assign out_data.mag_red   = chain[ROOT_W].lane[0].root[MAG_W-1:0];
  assign out_data.mag_green = chain[ROOT_W].lane[1].root[MAG_W-1:0];
  assign out_data.mag_blue  = chain[ROOT_W].lane[2].root[MAG_W-1:0];
  assign out_data.frame_end = chain[ROOT_W].frame_end;

endmodule

// ===== tb/sobel_rgb_gradient_magnitude_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for sobel_rgb_gradient_magnitude_top: drives pixel frames and drains, predicts
// every magnitude result in place and checks each result field by field. Uses sobel_pkg.
module sobel_rgb_gradient_magnitude_top_tb;
  import sobel_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sobel_rgb_gradient_magnitude_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Pixel requests waiting for the driver, and magnitudes waiting for the block.
  in_item_t pixel_q[$];
  out_item_t mag_q[$];
  int err_cnt = 0;
  int pixel_cnt = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;
  bit in_fire = 1'b0;

  // Shadow copy of the filter state: line stores, window, counters, registers.
  logic [PIX_W-1:0] line_up[MAX_LINE_WIDTH];
  logic [PIX_W-1:0] line_lo[MAX_LINE_WIDTH];
  logic [PIX_W-1:0] win[9];
  int col_pos = 0, row_pos = 0, out_pos = 0;
  logic [FW_W-1:0] fw_reg = FRAME_WIDTH_RST;
  logic [FH_W-1:0] fh_reg = FRAME_HEIGHT_RST;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int int_sqrt(input int v);
    int r;
    r = 0;
    for (int b = 10; b >= 0; b--)
      if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
    return r;
  endfunction

  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    out_pos = 0;
    for (int k = 0; k < 9; k++) win[k] = '0;
  endtask

  // Advance the shadow state by one accepted request; queue the magnitude it causes.
  task automatic predict_magnitude(input in_item_t it);
    int w, h, c, pos, orow, ocol, rr, cc, gx, gy;
    int v[9];
    int mag[3];
    bit done, emit;
    logic [PIX_W-1:0] pix;
    out_item_t res;
    w = (fw_reg < 2) ? 2 : (fw_reg > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : int'(fw_reg);
    h = (fh_reg < 2) ? 2 : int'(fh_reg);
    done = row_pos >= h;
    if (it.mode == MODE_DRAIN && !done) return;
    pix = done ? '0 : {it.in_blue, it.in_green, it.in_red};
    c = (col_pos >= MAX_LINE_WIDTH) ? 0 : col_pos;
    for (int r = 0; r < 3; r++) begin
      win[3*r] = win[3*r+1];
      win[3*r+1] = win[3*r+2];
    end
    win[2] = line_up[c];
    win[5] = line_lo[c];
    win[8] = pix;
    line_up[c] = line_lo[c];
    line_lo[c] = pix;
    emit = row_pos >= 2 || (row_pos == 1 && c >= 1);
    if (c + 1 >= w) begin
      col_pos = 0;
      if (row_pos < 'hFFFF) row_pos++;
    end else begin
      col_pos = c + 1;
    end
    if (!emit) return;
    pos = out_pos;
    orow = pos / w;
    ocol = pos % w;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        rr = orow + k / 3;
        cc = ocol + k % 3;
        v[k] = (rr >= 1 && rr <= h && cc >= 1 && cc <= w) ?
               int'((win[k] >> (CHANNEL_BITS * ch)) & 8'hFF) : 0;
      end
      gx = (v[2] + 2*v[5] + v[8]) - (v[0] + 2*v[3] + v[6]);
      gy = (v[0] + 2*v[1] + v[2]) - (v[6] + 2*v[7] + v[8]);
      mag[ch] = int_sqrt(gx*gx + gy*gy);
    end
    res.mag_red = mag[0][MAG_W-1:0];
    res.mag_green = mag[1][MAG_W-1:0];
    res.mag_blue = mag[2][MAG_W-1:0];
    if (pos + 1 >= w * h) begin
      res.frame_end = 1'b1;
      restart_frame();
    end else begin
      res.frame_end = 1'b0;
      out_pos = pos + 1;
    end
    mag_q.push_back(res);
  endtask

  // Sender: hold an offered request until it is taken, otherwise idle or advance.
  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
        tx_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  int rx_gap = 0, hold_cnt = 0, hold_seen = 0;
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_gap <= pick_gap();
    end
  end

  // Predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    out_item_t exp_mag;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) predict_magnitude(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (mag_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        exp_mag = mag_q.pop_front();
        if (out_data.mag_red !== exp_mag.mag_red) begin
          err_cnt++;
          $display("%0t: mag_red expected %0d actual %0d", $time,
                   exp_mag.mag_red, out_data.mag_red);
        end
        if (out_data.mag_green !== exp_mag.mag_green) begin
          err_cnt++;
          $display("%0t: mag_green expected %0d actual %0d", $time,
                   exp_mag.mag_green, out_data.mag_green);
        end
        if (out_data.mag_blue !== exp_mag.mag_blue) begin
          err_cnt++;
          $display("%0t: mag_blue expected %0d actual %0d", $time,
                   exp_mag.mag_blue, out_data.mag_blue);
        end
        if (out_data.frame_end !== exp_mag.frame_end) begin
          err_cnt++;
          $display("%0t: frame_end expected %0b actual %0b", $time,
                   exp_mag.frame_end, out_data.frame_end);
        end
      end
    end
  end

  // Write one register; the block is idle, so the shadow restarts at once.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) fw_reg = val[FW_W-1:0];
    else fh_reg = val[FH_W-1:0];
    restart_frame();
  endtask

  // Wait until all requests are taken and all results are in, then let the pipe drain.
  // Check at the rising edge, where the driver's outputs are settled.
  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_valid || mag_q.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  function automatic in_item_t make_pixel(input logic m, input int style);
    in_item_t it;
    it.mode = m;
    if (style == 1) begin
      it.in_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      it.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      it.in_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      it.in_red = $urandom;
      it.in_green = $urandom;
      it.in_blue = $urandom;
    end
    return it;
  endfunction

  // Queue one frame of w x h pixels plus its drains. A cut frame stops early and is
  // dropped by the next register write. Stray drains mid-frame are ignored by the block.
  task automatic send_frame(input int w, input int h, input bit cut, input bit pause_mid);
    int n, stop, style;
    n = w * h;
    stop = cut ? $urandom_range(1, n - 1) : n;
    style = $urandom_range(0, 3) == 0;
    for (int i = 0; i < stop; i++) begin
      if ($urandom_range(0, 99) < 3) pixel_q.push_back(make_pixel(MODE_DRAIN, 0));
      pixel_q.push_back(make_pixel(MODE_PIXEL, style));
      pixel_cnt++;
      if (pause_mid && i == stop / 2) wait_idle();
    end
    if (!cut) begin
      // Pixels past the frame end act as drains.
      for (int i = 0; i <= w; i++)
        pixel_q.push_back(make_pixel($urandom_range(0, 4) != 0 ? MODE_DRAIN : MODE_PIXEL, 0));
      if ($urandom_range(0, 3) == 0) pixel_q.push_back(make_pixel(MODE_DRAIN, 0));
    end
    wait_idle();
  endtask

  // Queue the first n pixels of a frame only; the next register write drops the rest.
  task automatic send_partial(input int n);
    for (int i = 0; i < n; i++) begin
      pixel_q.push_back(make_pixel(MODE_PIXEL, 0));
      pixel_cnt++;
    end
    wait_idle();
  endtask

  initial begin
    int w, h, phase;
    for (int k = 0; k < MAX_LINE_WIDTH; k++) begin
      line_up[k] = '0;
      line_lo[k] = '0;
    end
    restart_frame();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest frame: width and height below range clamp to 2x2. A drain before
    // any pixel, one inside the frame, and a pixel after completion acting as drain.
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    pixel_q.push_back(make_pixel(MODE_DRAIN, 0));
    pixel_q.push_back(in_item_t'{MODE_PIXEL, 8'hFF, 8'h00, 8'hFF});
    pixel_q.push_back(in_item_t'{MODE_PIXEL, 8'h00, 8'hFF, 8'h00});
    pixel_q.push_back(make_pixel(MODE_DRAIN, 0));
    pixel_q.push_back(in_item_t'{MODE_PIXEL, 8'h00, 8'hFF, 8'hFF});
    pixel_q.push_back(in_item_t'{MODE_PIXEL, 8'hFF, 8'h00, 8'h00});
    pixel_q.push_back(make_pixel(MODE_DRAIN, 0));
    pixel_q.push_back(make_pixel(MODE_PIXEL, 1));
    pixel_q.push_back(make_pixel(MODE_DRAIN, 0));
    pixel_q.push_back(make_pixel(MODE_DRAIN, 0));
    wait_idle();
    send_frame(2, 2, 1'b0, 1'b0);

    // Widest line: width above range clamps to the line store depth. One full line
    // and the start of the next, so the column wraps at the store depth.
    write_reg(CFG_FRAME_WIDTH, 2047);
    write_reg(CFG_FRAME_HEIGHT, 2);
    send_partial(MAX_LINE_WIDTH + 32);

    // Tallest frame at the narrowest width, only its first lines.
    write_reg(CFG_FRAME_WIDTH, 1);
    write_reg(CFG_FRAME_HEIGHT, 4095);
    send_partial(16);

    phase = 0;
    while (pixel_cnt < 1300 || phase < 5) begin
      no_idle = $urandom_range(0, 3) == 0;
      w = $urandom_range(2, 16);
      h = $urandom_range(2, 8);
      if (phase == 2) begin
        w = 16;
        h = 8;
        // Stall the receiver long enough that the block backs up into its input.
        hold_req++;
      end
      write_reg(CFG_FRAME_WIDTH, w);
      write_reg(CFG_FRAME_HEIGHT, h);
      send_frame(w, h, $urandom_range(0, 6) == 0, phase == 4);
      phase++;
    end

    wait_idle();
    repeat (30) @(negedge clk);
    if (err_cnt == 0) begin
      $display("sobel_rgb_gradient_magnitude_top_tb OK");
    end else begin
      $display("sobel_rgb_gradient_magnitude_top_tb NOT OK");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #20ms;
    $display("sobel_rgb_gradient_magnitude_top_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sobel_pkg.sv
rtl/sobel_ctrl.sv
rtl/sobel_window.sv
rtl/sobel_sqrt_cell.sv
rtl/sobel_rgb_gradient_magnitude_top.sv
tb/sobel_rgb_gradient_magnitude_top_tb.sv
